// ----- rtl/cdc_pkg.sv -----
`default_nettype none

package cdc_pkg;

    // window and length geometry
    localparam int WINDOW      = 32;
    localparam int LENGTH_BITS = 16;
    localparam int PTR_W       = $clog2(WINDOW);
    localparam int FILL_W      = $clog2(WINDOW + 1);

    // hash and rom
    localparam int HASH_W   = 32;
    localparam int ROT_W    = 5;
    localparam int ROM_SIZE = 256;
    localparam int BYTE_W   = 8;

    localparam logic [HASH_W-1:0] LCG_SEED = 32'h1234_5678;
    localparam logic [HASH_W-1:0] LCG_MUL  = 32'd1664525;
    localparam logic [HASH_W-1:0] LCG_ADD  = 32'd1013904223;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CHUNK_W    = 16;
    localparam int MASK_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_BITS = CFG_IDX_W'(2);

    localparam logic [CHUNK_W-1:0] MIN_CHUNK_RST = 16'd2048;
    localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST = 16'd65535;
    localparam logic [MASK_W-1:0]  MASK_BITS_RST = 5'd13;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              chunk_start;
        logic [31:0]       chunk_index;
        logic              stream_done;
    } t_out_item;

    typedef logic [HASH_W-1:0] t_rom [ROM_SIZE];

    function automatic t_rom gen_rom();
        t_rom              rom;
        logic [HASH_W-1:0] s;
        s = LCG_SEED;
        for (int k = 0; k < ROM_SIZE; k++) begin
            s      = s * LCG_MUL + LCG_ADD;
            rom[k] = s;
        end
        return rom;
    endfunction

    localparam t_rom HASH_ROM = gen_rom();

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x,
                                               input logic [ROT_W-1:0]  r);
        logic [2*HASH_W-1:0] d;
        d = {x, x} << r;
        return d[2*HASH_W-1:HASH_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cdc_out_queue.sv -----
`default_nettype none

module cdc_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cdc_pkg::t_out_item  i_push_data,
    output logic                o_push_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output cdc_pkg::t_out_item  o_data
);
    import cdc_pkg::*;

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_out_item  r_slot0;
    t_out_item  r_slot1;
    t_out_item  n_slot0;
    t_out_item  n_slot1;
    logic       w_pop;

    assign w_pop        = (r_count != 2'd0) && i_ready;
    assign o_valid      = (r_count != 2'd0);
    assign o_data       = r_slot0;
    assign o_push_ready = (r_count != 2'd2);

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count + 2'(i_push) - 2'(w_pop);
        // head advances on pop
        if (w_pop) begin
            n_slot0 = r_slot1;
        end
        if (i_push) begin
            if ((r_count == 2'd0) || ((r_count == 2'd1) && w_pop)) begin
                n_slot0 = i_push_data;
            end else begin
                n_slot1 = i_push_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full output queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output queue count out of range");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (r_count == 2'd2)) |=> (r_slot0 == $past(r_slot1)))
        else $error("output queue lost ordering");

endmodule

`default_nettype wire

// ----- rtl/content_defined_chunker_top.sv -----
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle in steady state while i_out_ready holds; a byte leaves WINDOW-1 accepted
// bytes after it entered, then passes through the output queue
// after an end-of-stream request the pending bytes (up to WINDOW-1, beside the one sent
// with the request when it fills the window) drain one per cycle while the output queue has room,
// paced by the single read port of the window memory; no input request is taken then
// i_rst_n is synchronous, active low: clears pointers, fill, hash, offset, chunk count
// and restores register defaults; the window memory is not cleared (read only once written)
// a two-entry output queue keeps taking requests while one result waits on i_out_ready
`default_nettype none

module content_defined_chunker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cdc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cdc_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cdc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cdc_pkg::*;

    // one window entry: the byte and its rom word, so removal needs no second lookup
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [HASH_W-1:0] hval;
    } t_entry;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // window memory, circular, written at r_wp and read ahead at the next oldest slot
    t_entry r_mem [WINDOW];
    t_entry r_old;              // entry at r_rd, registered read data with bypass

    // configuration
    logic [CHUNK_W-1:0]     r_min_chunk;
    logic [CHUNK_W-1:0]     r_max_chunk;
    logic [MASK_W-1:0]      r_mask_bits;

    // stream state
    logic [PTR_W-1:0]       r_wp, n_wp;
    logic [PTR_W-1:0]       r_rd, n_rd;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [LENGTH_BITS-1:0] r_offset, n_offset;
    logic [31:0]            r_chunk, n_chunk;
    logic                   r_drain, n_drain;

    logic                   w_push_ready;
    logic                   w_in_fire;
    t_entry                 w_new_entry;
    logic [HASH_W-1:0]      w_hash_add;
    logic [FILL_W-1:0]      w_fill_add;
    logic [FILL_W-1:0]      w_fill_cur;
    logic [FILL_W-1:0]      w_send_gap;
    logic [FILL_W-1:0]      w_rm_amt;
    logic [HASH_W-1:0]      w_base;
    logic [HASH_W-1:0]      w_send_hash;
    logic [HASH_W-1:0]      w_hash_after;
    logic                   w_full_send;
    logic                   w_drain_send;
    logic                   w_send;
    logic                   w_last;
    logic [CHUNK_W-1:0]     w_lo;
    logic [CHUNK_W-1:0]     w_hi;
    logic [HASH_W-1:0]      w_mask;
    logic                   w_hit;
    logic                   w_boundary;
    logic                   w_start;
    logic [31:0]            w_chunk_idx;
    logic [LENGTH_BITS-1:0] w_off_next;
    t_out_item              w_result;
    logic [PTR_W:0]         w_used;

    // input taken only outside the end-of-stream drain and with room in the queue
    assign o_in_ready  = !r_drain && w_push_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // rolling hash with the new byte folded in
    assign w_new_entry = '{data_byte: i_in_data.data_byte,
                           hval:      HASH_ROM[i_in_data.data_byte]};
    assign w_hash_add  = rotl(r_hash, ROT_W'(1)) ^ w_new_entry.hval;
    assign w_fill_add  = r_fill + FILL_W'(1);

    // a send happens when the window fills, or once per cycle while draining with room in the queue
    assign w_full_send  = w_in_fire && (w_fill_add == FILL_W'(WINDOW));
    assign w_drain_send = r_drain && w_push_ready;
    assign w_send       = w_full_send || w_drain_send;
    assign w_last       = r_drain && (r_fill == FILL_W'(1));

    // window hash of the oldest byte: missing bytes past the end contribute nothing,
    // so the pending hash is rotated up to full-window alignment
    assign w_base       = r_drain ? r_hash : w_hash_add;
    assign w_fill_cur   = r_drain ? r_fill : w_fill_add;
    assign w_send_gap   = FILL_W'(WINDOW) - w_fill_cur;
    assign w_rm_amt     = w_fill_cur - FILL_W'(1);
    assign w_send_hash  = rotl(w_base, w_send_gap[ROT_W-1:0]);
    // drop the oldest byte's term from the pending hash
    assign w_hash_after = w_base ^ rotl(r_old.hval, w_rm_amt[ROT_W-1:0]);

    // boundary decision; zero limits act as one
    assign w_lo       = (r_min_chunk == '0) ? CHUNK_W'(1) : r_min_chunk;
    assign w_hi       = (r_max_chunk == '0) ? CHUNK_W'(1) : r_max_chunk;
    assign w_mask     = ~({HASH_W{1'b1}} << r_mask_bits);
    assign w_hit      = ((w_send_hash & w_mask) == '0);
    assign w_boundary = (r_offset != '0)
                        && ((32'(r_offset) >= 32'(w_hi))
                            || ((32'(r_offset) >= 32'(w_lo)) && w_hit));
    assign w_start     = (r_offset == '0) || w_boundary;
    assign w_chunk_idx = w_boundary ? r_chunk + 32'd1 : r_chunk;
    assign w_off_next  = w_boundary ? LENGTH_BITS'(1) : r_offset + LENGTH_BITS'(1);

    assign w_result = '{out_byte:    r_old.data_byte,
                        chunk_start: w_start,
                        chunk_index: w_chunk_idx,
                        stream_done: w_last};

    always_comb begin
        n_wp     = r_wp;
        n_rd     = r_rd;
        n_fill   = r_fill;
        n_hash   = r_hash;
        n_offset = r_offset;
        n_chunk  = r_chunk;
        n_drain  = r_drain;
        if (w_in_fire) begin
            n_wp   = ptr_inc(r_wp);
            n_fill = w_fill_add;
            n_hash = w_hash_add;
            if (i_in_data.end_of_stream) begin
                n_drain = 1'b1;
            end
        end
        if (w_send) begin
            n_rd     = ptr_inc(r_rd);
            n_fill   = w_fill_cur - FILL_W'(1);
            n_hash   = w_hash_after;
            n_offset = w_off_next;
            n_chunk  = w_chunk_idx;
        end
        // stream finished: next byte opens a fresh stream at chunk zero
        if (w_send && w_last) begin
            n_fill   = '0;
            n_hash   = '0;
            n_offset = '0;
            n_chunk  = '0;
            n_drain  = 1'b0;
        end
    end

    // window memory write and read-ahead of the next oldest entry, bypassing a same-slot write
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mem[r_wp] <= w_new_entry;
        end
        if (w_in_fire && (r_wp == n_rd)) begin
            r_old <= w_new_entry;
        end else begin
            r_old <= r_mem[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rd        <= '0;
            r_fill      <= '0;
            r_hash      <= '0;
            r_offset    <= '0;
            r_chunk     <= '0;
            r_drain     <= 1'b0;
            r_min_chunk <= MIN_CHUNK_RST;
            r_max_chunk <= MAX_CHUNK_RST;
            r_mask_bits <= MASK_BITS_RST;
        end else begin
            r_wp     <= n_wp;
            r_rd     <= n_rd;
            r_fill   <= n_fill;
            r_hash   <= n_hash;
            r_offset <= n_offset;
            r_chunk  <= n_chunk;
            r_drain  <= n_drain;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_CHUNK: r_min_chunk <= i_cfg_data[CHUNK_W-1:0];
                    CFG_MAX_CHUNK: r_max_chunk <= i_cfg_data[CHUNK_W-1:0];
                    CFG_MASK_BITS: r_mask_bits <= i_cfg_data[MASK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // result queue decouples the send decision from the output handshake
    cdc_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_send),
        .i_push_data  (w_result),
        .o_push_ready (w_push_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

    // pointer distance, checked against the fill count
    assign w_used = (r_wp >= r_rd)
                    ? ({1'b0, r_wp} - {1'b0, r_rd})
                    : ({1'b0, r_wp} + (PTR_W + 1)'(WINDOW) - {1'b0, r_rd});

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(WINDOW))
        else $error("window fill reached capacity between requests");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_used) == 32'(r_fill))
        else $error("window pointers disagree with fill count");

    a_drain_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_fill != '0))
        else $error("drain with empty window");

    a_full_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_send && !r_drain) |-> (w_in_fire && (r_fill == FILL_W'(WINDOW - 1))))
        else $error("send outside drain without a full window");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_send && w_last) |=> (!r_drain && (r_fill == '0) && (r_chunk == '0)
                                && (r_offset == '0) && (r_hash == '0)))
        else $error("stream state not cleared after final byte");

endmodule

`default_nettype wire

// ----- tb/tb_content_defined_chunker_top.sv -----
module tb_content_defined_chunker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdc_pkg::*;

    // run shape
    localparam int RAND_ITEMS   = 180;
    localparam int DRAIN_CYCLES = WINDOW + 8;   // pipeline + output queue, with margin
    localparam int HOLD_CYCLES  = 150;          // long receiver stall, fills window and queue
    localparam int IDLE_LIMIT   = 2000;         // cycles with no handshake at all
    localparam int MAX_REPORTS  = 10;

    // register index that decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    content_defined_chunker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shared between the request driver, the result sink and the checkers
    logic gaps_on  = 1'b1;  // random idle cycles on both sides
    logic hold_out = 1'b0;  // one-shot long stall of the result sink
    int   err_count = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;

    // ------------------------------------------------------------------
    // chunker predictor: own copy of hash table, window, hash, offset,
    // chunk count and registers
    // ------------------------------------------------------------------
    logic [31:0] hash_tbl [256];
    logic [7:0]  window_q [$];      // pending bytes, oldest first
    logic [31:0] roll_hash;         // hash over pending bytes
    logic [15:0] chunk_off;         // offset of next byte sent inside its chunk
    logic [31:0] chunk_cnt;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [4:0]  mask_len;
    t_out_item   chunked_bytes_due [$];

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned r);
        int unsigned s;
        s = r % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void chunker_clear();
        logic [31:0] s;
        // table from the lcg, same seed and constants as the hardware rom
        s = 32'h1234_5678;
        for (int k = 0; k < 256; k++) begin
            s = s * 32'd1664525 + 32'd1013904223;
            hash_tbl[k] = s;
        end
        window_q.delete();
        roll_hash = '0;
        chunk_off = '0;
        chunk_cnt = '0;
        min_len   = 16'd2048;
        max_len   = 16'd65535;
        mask_len  = 5'd13;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MIN_CHUNK: min_len = val;
            CFG_MAX_CHUNK: max_len = val;
            CFG_MASK_BITS: mask_len = val[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    // send the oldest pending byte, h is the hash of the window starting at it
    function automatic void release_oldest(input logic [31:0] h, input logic last);
        int unsigned lo;
        int unsigned hi;
        int unsigned off;
        logic [31:0] mask;
        logic [7:0]  b;
        logic        start;
        t_out_item   res;
        // zero lengths behave as one
        lo   = (min_len == 0) ? 1 : min_len;
        hi   = (max_len == 0) ? 1 : max_len;
        mask = (mask_len == 0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - mask_len));
        off  = chunk_off;
        b    = window_q[0];
        if (off == 0) begin
            start = 1'b1;
        end else if (off >= hi || (off >= lo && (h & mask) == 0)) begin
            start     = 1'b1;
            chunk_cnt = chunk_cnt + 1;
            off       = 0;
        end else begin
            start = 1'b0;
        end
        res = '{out_byte: b, chunk_start: start, chunk_index: chunk_cnt, stream_done: last};
        chunked_bytes_due = {chunked_bytes_due, res};
        chunk_off = 16'(off + 1);
        // drop the byte from the rolling hash at its current rotation
        roll_hash ^= rot_left(hash_tbl[b], window_q.size() - 1);
        void'(window_q.pop_front());
    endfunction

    function automatic void chunk_byte_in(input logic [7:0] b, input logic eos);
        roll_hash = rot_left(roll_hash, 1) ^ hash_tbl[b];
        if (window_q.size() < WINDOW)
            window_q = {window_q, b};
        if (window_q.size() == WINDOW)
            release_oldest(roll_hash, 1'b0);
        if (eos) begin
            // flush: bytes past the end are absent from each window
            while (window_q.size() > 0)
                release_oldest(rot_left(roll_hash, WINDOW - window_q.size()),
                               window_q.size() == 1);
            roll_hash = '0;
            chunk_off = '0;
            chunk_cnt = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // request driver tasks
    // ------------------------------------------------------------------

    // one byte request; n_new tells how many results it raised
    task automatic send_byte(input logic [7:0] b, input logic eos, output int n_new);
        int gap;
        int n_old;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, end_of_stream: eos};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_old = chunked_bytes_due.size();
        chunk_byte_in(b, eos);
        n_new = chunked_bytes_due.size() - n_old;
    endtask

    // stop offering, wait until every result is back, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (chunked_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // registers are only touched with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // directed script
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        ROW_BYTE,   // byte request, checked against the predictor
        ROW_KNOWN,  // single-byte stream, result typed in the row
        ROW_REG     // register write
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [7:0]            data;
        logic                  eos;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  want_start;
        logic [31:0]           want_index;
        logic                  want_done;
    } t_script_row;

    localparam int SCRIPT_LEN = 26;
    t_script_row script [SCRIPT_LEN];

    initial begin
        script = '{
            // lone bytes after reset: chunk 0, first and last
            '{ROW_KNOWN, 8'h00, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b1, 32'd0, 1'b1},
            '{ROW_KNOWN, 8'hFF, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b1, 32'd0, 1'b1},
            // forced boundary on every byte
            '{ROW_REG,   8'h00, 1'b0, CFG_MAX_CHUNK, 16'd1, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h01, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h80, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'hFE, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            // zero lengths and zero mask
            '{ROW_REG,   8'h00, 1'b0, CFG_MAX_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MASK_BITS, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'hAA, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h55, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h0F, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            // smallest min, largest max, wide masks
            '{ROW_REG,   8'h00, 1'b0, CFG_MIN_CHUNK, 16'd1, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MAX_CHUNK, 16'hFFFF, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MASK_BITS, 16'd16, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h11, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h22, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h33, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MASK_BITS, 16'd31, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h44, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'h99, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            // largest min, zero mask
            '{ROW_REG,   8'h00, 1'b0, CFG_MIN_CHUNK, 16'hFFFF, 1'b0, 32'd0, 1'b0},
            '{ROW_REG,   8'h00, 1'b0, CFG_MASK_BITS, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_KNOWN, 8'hC3, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b1, 32'd0, 1'b1},
            '{ROW_BYTE,  8'h3C, 1'b0, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0},
            '{ROW_BYTE,  8'hE7, 1'b1, CFG_MIN_CHUNK, 16'd0, 1'b0, 32'd0, 1'b0}
        };
    end

    // ------------------------------------------------------------------
    // result sink: random stalls, plus one long stall on demand
    // ------------------------------------------------------------------
    initial begin : out_sink
        int gap;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_out) begin
                // long stall counted here while the driver keeps offering
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // result check, oldest expectation first
    // ------------------------------------------------------------------
    function automatic void flag_error(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("result %0d: %s expected %0h, got %0h", results_seen, what, want, got);
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (chunked_bytes_due.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("result %0d: unexpected byte %0h", results_seen,
                             o_out_data.out_byte);
            end else begin
                want = chunked_bytes_due.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    flag_error("out_byte", want.out_byte, o_out_data.out_byte);
                if (o_out_data.chunk_start !== want.chunk_start)
                    flag_error("chunk_start", want.chunk_start, o_out_data.chunk_start);
                if (o_out_data.chunk_index !== want.chunk_index)
                    flag_error("chunk_index", want.chunk_index, o_out_data.chunk_index);
                if (o_out_data.stream_done !== want.stream_done)
                    flag_error("stream_done", want.stream_done, o_out_data.stream_done);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // watchdog on handshake activity
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stim
        int              rand_items;
        int              stream_len;
        int              n_streams;
        int              n_new;
        logic [15:0]     lo_pick;
        logic [15:0]     hi_pick;
        logic [4:0]      mask_pick;
        logic            hold_done;
        logic            pause_done;
        t_out_item       typed_res;

        // every input known from time zero
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MIN_CHUNK;
        i_cfg_data  <= '0;
        chunker_clear();
        rand_items = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            case (script[r].kind)
                ROW_REG: write_reg(script[r].reg_idx, script[r].reg_val);
                ROW_BYTE: send_byte(script[r].data, script[r].eos, n_new);
                default: begin
                    // typed result stands in for the predicted one
                    send_byte(script[r].data, script[r].eos, n_new);
                    repeat (n_new) void'(chunked_bytes_due.pop_back());
                    typed_res = '{out_byte: script[r].data,
                                  chunk_start: script[r].want_start,
                                  chunk_index: script[r].want_index,
                                  stream_done: script[r].want_done};
                    chunked_bytes_due = {chunked_bytes_due, typed_res};
                end
            endcase
        end

        // random phases: new settings, then a few whole streams
        while (rand_items < RAND_ITEMS) begin
            case ($urandom_range(0, 7))
                0: lo_pick = 16'd0;
                1: lo_pick = 16'($urandom_range(0, 65535));
                default: lo_pick = 16'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 7))
                0: hi_pick = 16'hFFFF;
                1: hi_pick = 16'($urandom_range(0, 65535));
                2: hi_pick = 16'($urandom_range(0, 3));
                default: hi_pick = 16'($urandom_range(8, 100));
            endcase
            // mostly small masks so content boundaries show up often
            mask_pick = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(7, 31))
                                                     : 5'($urandom_range(0, 6));
            write_reg(CFG_MIN_CHUNK, lo_pick);
            write_reg(CFG_MAX_CHUNK, hi_pick);
            // upper data bits are don't-care for the mask register
            write_reg(CFG_MASK_BITS, {11'($urandom_range(0, 2047)), mask_pick});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, 16'($urandom));

            n_streams = $urandom_range(1, 3);
            for (int s = 0; s < n_streams && rand_items < RAND_ITEMS; s++) begin
                gaps_on    = ($urandom_range(0, 3) != 0);
                stream_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
                                                          : $urandom_range(32, 80);
                if (!hold_done) begin
                    // back-to-back requests against a stalled sink
                    stream_len = 90;
                    gaps_on    = 1'b0;
                    hold_out   = 1'b1;
                    hold_done  = 1'b1;
                end
                for (int k = 0; k < stream_len; k++) begin
                    if (!pause_done && rand_items >= 100 && k > 0 && k == stream_len / 2) begin
                        // mid-stream pause until every result so far is back
                        i_in_valid <= 1'b0;
                        @(posedge i_clk);
                        while (chunked_bytes_due.size() != 0) @(posedge i_clk);
                        pause_done = 1'b1;
                    end
                    send_byte(8'($urandom_range(0, 255)), k == stream_len - 1, n_new);
                    rand_items++;
                end
            end
        end

        // drain and report
        settle();
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
